@@ hw/rtl/kws_pkg.sv @@
package kws_pkg;

    localparam int WordW  = 32;
    localparam int PosW   = 4;
    localparam int RoundW = 6;
    localparam int WinLen = 16;

    localparam logic [PosW-1:0]   LastMsgPos = 4'd15;
    localparam logic [RoundW-1:0] FirstExpRound = 6'd16;
    localparam logic [RoundW-1:0] LastRound = 6'd63;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        word_t           word;
        logic [PosW-1:0] pos;
    } job_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t round_k(input logic [RoundW-1:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428A2F98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hB5C0FBCF;
            6'd3:  round_k = 32'hE9B5DBA5;
            6'd4:  round_k = 32'h3956C25B;
            6'd5:  round_k = 32'h59F111F1;
            6'd6:  round_k = 32'h923F82A4;
            6'd7:  round_k = 32'hAB1C5ED5;
            6'd8:  round_k = 32'hD807AA98;
            6'd9:  round_k = 32'h12835B01;
            6'd10: round_k = 32'h243185BE;
            6'd11: round_k = 32'h550C7DC3;
            6'd12: round_k = 32'h72BE5D74;
            6'd13: round_k = 32'h80DEB1FE;
            6'd14: round_k = 32'h9BDC06A7;
            6'd15: round_k = 32'hC19BF174;
            6'd16: round_k = 32'hE49B69C1;
            6'd17: round_k = 32'hEFBE4786;
            6'd18: round_k = 32'h0FC19DC6;
            6'd19: round_k = 32'h240CA1CC;
            6'd20: round_k = 32'h2DE92C6F;
            6'd21: round_k = 32'h4A7484AA;
            6'd22: round_k = 32'h5CB0A9DC;
            6'd23: round_k = 32'h76F988DA;
            6'd24: round_k = 32'h983E5152;
            6'd25: round_k = 32'hA831C66D;
            6'd26: round_k = 32'hB00327C8;
            6'd27: round_k = 32'hBF597FC7;
            6'd28: round_k = 32'hC6E00BF3;
            6'd29: round_k = 32'hD5A79147;
            6'd30: round_k = 32'h06CA6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27B70A85;
            6'd33: round_k = 32'h2E1B2138;
            6'd34: round_k = 32'h4D2C6DFC;
            6'd35: round_k = 32'h53380D13;
            6'd36: round_k = 32'h650A7354;
            6'd37: round_k = 32'h766A0ABB;
            6'd38: round_k = 32'h81C2C92E;
            6'd39: round_k = 32'h92722C85;
            6'd40: round_k = 32'hA2BFE8A1;
            6'd41: round_k = 32'hA81A664B;
            6'd42: round_k = 32'hC24B8B70;
            6'd43: round_k = 32'hC76C51A3;
            6'd44: round_k = 32'hD192E819;
            6'd45: round_k = 32'hD6990624;
            6'd46: round_k = 32'hF40E3585;
            6'd47: round_k = 32'h106AA070;
            6'd48: round_k = 32'h19A4C116;
            6'd49: round_k = 32'h1E376C08;
            6'd50: round_k = 32'h2748774C;
            6'd51: round_k = 32'h34B0BCB5;
            6'd52: round_k = 32'h391C0CB3;
            6'd53: round_k = 32'h4ED8AA4A;
            6'd54: round_k = 32'h5B9CCA4F;
            6'd55: round_k = 32'h682E6FF3;
            6'd56: round_k = 32'h748F82EE;
            6'd57: round_k = 32'h78A5636F;
            6'd58: round_k = 32'h84C87814;
            6'd59: round_k = 32'h8CC70208;
            6'd60: round_k = 32'h90BEFFFA;
            6'd61: round_k = 32'hA4506CEB;
            6'd62: round_k = 32'hBEF9A3F7;
            6'd63: round_k = 32'hC67178F2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

@@ hw/rtl/kws_if.sv @@
interface kws_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic        block_start;

    modport source (output valid, output msg_word, output block_start, input ready);
    modport sink (input valid, input msg_word, input block_start, output ready);
endinterface

interface kws_kw_if;
    logic        valid;
    logic        ready;
    logic [31:0] kw_value;
    logic [5:0]  kw_index;
    logic        kw_last;

    modport source (output valid, output kw_value, output kw_index, output kw_last,
                    input ready);
    modport sink (input valid, input kw_value, input kw_index, input kw_last,
                  output ready);
endinterface

@@ hw/rtl/kws_front.sv @@
module kws_front (
    input  logic           clk,
    input  logic           rst_n,
    kws_msg_if.sink        msg,
    output logic           push_valid,
    input  logic           push_ready,
    output kws_pkg::job_t  push_job
);

    logic [kws_pkg::PosW-1:0] count_reg;
    logic [kws_pkg::PosW-1:0] count_next;
    logic [kws_pkg::PosW-1:0] pos;
    logic                     accept;

    assign msg.ready  = push_ready;
    assign push_valid = msg.valid;
    assign accept     = msg.valid && push_ready;

    // a start request forces word 0 and drops any partial block
    assign pos        = msg.block_start ? '0 : count_reg;
    assign count_next = pos + 1'b1;

    assign push_job.word = msg.msg_word;
    assign push_job.pos  = pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/kws_fifo.sv @@
module kws_fifo #(
    parameter int Depth = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  kws_pkg::job_t  push_job,
    output logic           pop_valid,
    input  logic           pop,
    output kws_pkg::job_t  pop_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    kws_pkg::job_t   mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntFull);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/kws_back.sv @@
module kws_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           pop,
    input  kws_pkg::job_t  job,
    output logic           busy,
    kws_kw_if.source       kw
);

    kws_pkg::word_t             win_reg [kws_pkg::WinLen];
    logic                       busy_reg;
    logic [kws_pkg::RoundW-1:0] rnd_reg;
    logic                       out_valid_reg;
    kws_pkg::word_t             kw_value_reg;
    logic [kws_pkg::RoundW-1:0] kw_index_reg;
    logic                       kw_last_reg;

    logic                       advance;
    logic                       shift;
    kws_pkg::word_t             w_new;
    kws_pkg::word_t             val;
    logic [kws_pkg::RoundW-1:0] idx;
    kws_pkg::word_t             kw_next;

    assign advance = !out_valid_reg || kw.ready;
    assign pop     = advance && !busy_reg && job_valid;
    assign shift   = advance && (busy_reg || job_valid);
    assign busy    = busy_reg;

    // taps: W[i-16], W[i-15], W[i-7], W[i-2]
    assign w_new = win_reg[0] + kws_pkg::small_sigma0(win_reg[1]) + win_reg[9]
                 + kws_pkg::small_sigma1(win_reg[14]);

    always_comb
    begin
        if (busy_reg)
        begin
            val = w_new;
            idx = rnd_reg;
        end
        else
        begin
            val = job.word;
            idx = {2'b00, job.pos};
        end
    end

    assign kw_next = kws_pkg::round_k(idx) + val;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < kws_pkg::WinLen - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[kws_pkg::WinLen - 1] <= val;
            kw_value_reg <= kw_next;
            kw_index_reg <= idx;
            kw_last_reg  <= busy_reg && (rnd_reg == kws_pkg::LastRound);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= shift;
            if (pop && (job.pos == kws_pkg::LastMsgPos))
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= kws_pkg::FirstExpRound;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 1'b1;
                if (rnd_reg == kws_pkg::LastRound)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign kw.valid    = out_valid_reg;
    assign kw.kw_value = kw_value_reg;
    assign kw.kw_index = kw_index_reg;
    assign kw.kw_last  = kw_last_reg;

endmodule

@@ hw/rtl/sha256_kw_schedule.sv @@
// SHA-256 K+W schedule.
// msg (sink): one 32-bit message word per request; block_start marks word 0
//   and restarts the word count. Words 0..15 of a block arrive in order.
// kw (source): one request per round with K[i]+W[i], the round index and a
//   last flag on round 63.
// Each message word yields one result, registered in the queue and then in
// the output register. Word 15 also starts the expansion of W16..W63, which
// the back end produces one per cycle while kw does not stall, and no queued
// word is taken meanwhile. Sustained: 64 results per 16 words, set by the
// single expansion adder emitting one round per cycle.
// A QueueDepth-entry queue decouples intake from the back end, so words of
// the next block are taken while an expansion runs until the queue fills.
// When kw stalls, the output register holds its request, the back end stops
// and the queue fills; msg.ready then drops.
// Reset clears the word count, the queue and the output valid; the schedule
// window holds no valid data until a block has been loaded.
module sha256_kw_schedule #(
    parameter int QueueDepth = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    kws_msg_if.sink   msg,
    kws_kw_if.source  kw
);

    logic          push_valid;
    logic          push_ready;
    kws_pkg::job_t push_job;
    logic          pop_valid;
    logic          pop;
    kws_pkg::job_t pop_job;
    logic          busy;

    kws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    kws_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    kws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .pop       (pop),
        .job       (pop_job),
        .busy      (busy),
        .kw        (kw)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pop)
        else $error("queue popped during expansion");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(pop) && ($past(pop_job.pos) == kws_pkg::LastMsgPos))
        else $error("expansion started without word 15");

    assert property (@(posedge clk) disable iff (!rst_n)
        kw.valid && (kw.kw_index == kws_pkg::LastRound) |-> kw.kw_last)
        else $error("round 63 not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        kw.valid && kw.kw_last |-> (kw.kw_index == kws_pkg::LastRound))
        else $error("last flag on wrong round");

endmodule
